// ----- sv/fixed_point_q24_8_alu_defines.svh -----
// Assertion macros used by the ALU top module.
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define FXA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define FXA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication checked at every clock edge, reset included.
`define FXA_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/fxa_pkg.sv -----
package fxa_pkg;

  localparam int FRAC_BITS = 8;
  // Quotient bits kept by the divider: 2^33 and above is certain overflow.
  localparam int QW = 33;
  // Partial remainder width, large enough for the scaled dividend and divisor << QW.
  localparam int RW = 66;
  localparam int DIV_STAGES = QW;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_CMP      = 4'd4,
    OP_MIN      = 4'd5,
    OP_MAX      = 4'd6,
    OP_INC      = 4'd7,
    OP_DEC      = 4'd8,
    OP_FROM_INT = 4'd9,
    OP_TO_INT   = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // Per-item control and the result of every operation but divide.
  typedef struct packed {
    logic [3:0]  op;
    logic        neg;
    logic        bzero;
    logic [31:0] res;
    logic [1:0]  st;
    logic        lt;
    logic        eq;
    logic        gt;
  } ctl_t;

  // Everything one divider stage holds.
  typedef struct packed {
    ctl_t          ctl;
    logic [RW-1:0] rem;
    logic [QW-1:0] e;
    logic [QW-1:0] q;
    logic          ovf;
  } dstage_t;

  typedef struct packed {
    logic [31:0] res;
    logic        ovf;
  } sat_t;

  // Clamp a signed 64-bit value to the signed 32-bit range.
  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t s;
    s.ovf = 1'b1;
    if (v > 64'sd2147483647) begin
      s.res = SAT_MAX;
    end else if (v < -64'sd2147483648) begin
      s.res = SAT_MIN;
    end else begin
      s.res = v[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  // Give an unsigned magnitude its sign, clamping to the 32-bit range.
  function automatic sat_t sign_sat(input logic [64:0] m, input logic neg);
    sat_t s;
    s.ovf = 1'b0;
    if (neg) begin
      if (m > 65'h0_8000_0000) begin
        s.res = SAT_MIN;
        s.ovf = 1'b1;
      end else begin
        s.res = ~m[31:0] + 32'd1;
      end
    end else begin
      if (m > 65'h0_7fff_ffff) begin
        s.res = SAT_MAX;
        s.ovf = 1'b1;
      end else begin
        s.res = m[31:0];
      end
    end
    return s;
  endfunction

endpackage

// ----- sv/fixed_point_q24_8_alu.sv -----
// Channel   Signals                                      Direction
// item      item_valid, item_stall, opcode, operand_a/b  in (stall out)
// result    result_valid, result_stall, result, status,  out (stall in)
//           a_less, a_equal, a_greater
//
// One item can be accepted in every cycle that the result is not stalled. The
// depth is set by the divider, which retires one quotient bit per stage over
// 33 stages, behind three front stages.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled result freezes the whole pipeline, so item_stall follows it.
`include "fixed_point_q24_8_alu_defines.svh"

module fixed_point_q24_8_alu
  import fxa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] result,
  output logic [1:0]         status,
  output logic               a_less,
  output logic               a_equal,
  output logic               a_greater
);

  // The pipeline moves whenever the output register is empty or being taken.
  logic    en;
  logic    f_valid, d_valid;
  dstage_t f_data, d_data;
  sat_t    sdiv;
  logic [31:0] res_next;
  logic [1:0]  st_next;

  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;

  fxa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (item_valid),
    .opcode     (opcode),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .valid      (f_valid),
    .data       (f_data)
  );

  fxa_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (f_valid),
    .data_in  (f_data),
    .valid    (d_valid),
    .data     (d_data)
  );

  assign sdiv = sign_sat({{(65-QW){1'b0}}, d_data.q}, d_data.ctl.neg);

  // Divide is resolved here; every other operation already carries its result.
  always_comb begin
    res_next = d_data.ctl.res;
    st_next  = d_data.ctl.st;
    if (d_data.ctl.op == OP_DIV) begin
      if (d_data.ctl.bzero) begin
        res_next = 32'd0;
        st_next  = ST_DIV0;
      end else if (d_data.ovf) begin
        res_next = d_data.ctl.neg ? SAT_MIN : SAT_MAX;
        st_next  = ST_OVF;
      end else begin
        res_next = sdiv.res;
        st_next  = sdiv.ovf ? ST_OVF : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result    <= res_next;
      status    <= st_next;
      a_less    <= d_data.ctl.lt;
      a_equal   <= d_data.ctl.eq;
      a_greater <= d_data.ctl.gt;
    end
  end

  // Exactly one of the three comparison flags is set on every result.
  `FXA_ASSERT_IMPL(a_flags_onehot, result_valid, $onehot({a_less, a_equal, a_greater}), "flags not one-hot")
  // Status code three is never produced.
  `FXA_ASSERT_IMPL(a_status_legal, result_valid, status != 2'd3, "illegal status")
  // Right after reset the pipeline is empty.
  `FXA_ASSERT_RST(a_reset_empty, $past(rst), !result_valid && !f_valid && !d_valid, "valid after reset")

endmodule

// ----- sv/fxa_front.sv -----
module fxa_front
  import fxa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               item_valid,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               valid,
  output dstage_t            data
);

  logic [2:0]  vld;
  ctl_t        ctl1, ctl2, ctl1_next;
  logic [31:0] mag_a, mag_b;
  logic [63:0] prod;
  logic [RW-1:0] dvd;
  logic [QW-1:0] dvs;

  logic signed [63:0] a64, b64;
  sat_t s1;
  logic [64:0] mround;
  sat_t smul;
  dstage_t data_next;

  assign a64 = {{32{operand_a[31]}}, operand_a};
  assign b64 = {{32{operand_b[31]}}, operand_b};

  always_comb begin
    s1 = '{res: 32'd0, ovf: 1'b0};
    unique case (opcode)
      OP_ADD:      s1 = sat64(a64 + b64);
      OP_SUB:      s1 = sat64(a64 - b64);
      OP_MIN:      s1.res = (operand_a > operand_b) ? operand_b : operand_a;
      OP_MAX:      s1.res = (operand_a > operand_b) ? operand_a : operand_b;
      OP_INC:      s1 = sat64(a64 + 64'sd1);
      OP_DEC:      s1 = sat64(a64 - 64'sd1);
      OP_FROM_INT: s1 = sat64(a64 <<< FRAC_BITS);
      OP_TO_INT:   s1.res = operand_a >>> FRAC_BITS;
      default:     s1 = '{res: 32'd0, ovf: 1'b0};
    endcase
    ctl1_next.op    = opcode;
    ctl1_next.neg   = operand_a[31] ^ operand_b[31];
    ctl1_next.bzero = (operand_b == 32'sd0);
    ctl1_next.res   = s1.res;
    ctl1_next.st    = s1.ovf ? ST_OVF : ST_OK;
    ctl1_next.lt    = operand_a < operand_b;
    ctl1_next.eq    = operand_a == operand_b;
    ctl1_next.gt    = operand_a > operand_b;
  end

  // Multiply rounding: add half an LSB to the magnitude, then drop the fraction.
  assign mround = ({1'b0, prod} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign smul   = sign_sat(mround, ctl2.neg);

  always_comb begin
    data_next.ctl = ctl2;
    if (ctl2.op == OP_MUL) begin
      data_next.ctl.res = smul.res;
      data_next.ctl.st  = smul.ovf ? ST_OVF : ST_OK;
    end
    data_next.rem = dvd;
    data_next.e   = dvs;
    data_next.q   = '0;
    data_next.ovf = dvd >= {dvs, {QW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1  <= ctl1_next;
      mag_a <= operand_a[31] ? (~operand_a + 32'd1) : operand_a;
      mag_b <= operand_b[31] ? (~operand_b + 32'd1) : operand_b;

      ctl2 <= ctl1;
      prod <= mag_a * mag_b;
      // Rounded quotient is (2*|a|*2^F + |b|) / (2*|b|).
      dvd  <= ({34'd0, mag_a} << (FRAC_BITS + 1)) + {34'd0, mag_b};
      dvs  <= {mag_b, 1'b0};

      data <= data_next;
    end
  end

  assign valid = vld[2];

endmodule

// ----- sv/fxa_div_pipe.sv -----
module fxa_div_pipe
  import fxa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    valid_in,
  input  dstage_t data_in,
  output logic    valid,
  output dstage_t data
);

  logic    vld [DIV_STAGES];
  dstage_t stg [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic          v_src;
    dstage_t       d_src;
    dstage_t       d_next;
    logic [RW-1:0] sh;
    logic          take;

    if (j == 0) begin : g_first
      assign v_src = valid_in;
      assign d_src = data_in;
    end else begin : g_rest
      assign v_src = vld[j-1];
      assign d_src = stg[j-1];
    end

    assign sh   = {{(RW-QW){1'b0}}, d_src.e} << K;
    assign take = d_src.rem >= sh;

    always_comb begin
      d_next = d_src;
      if (take) begin
        d_next.rem = d_src.rem - sh;
      end
      d_next.q[K] = take;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[j] <= d_next;
      end
    end
  end

  assign valid = vld[DIV_STAGES-1];
  assign data  = stg[DIV_STAGES-1];

endmodule
